// File: rtl/core/sitda_pkg.sv
package sitda_pkg;

   localparam int VALUE_W        = 32;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 4;
   localparam int NUM_DIGITS     = 10;
   localparam int DIGIT_IDX_W    = 4;
   localparam int BITS_PER_CYCLE = 4;
   localparam int CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
   localparam int CONV_CNT_W     = 3;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT
   } sitda_state_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } sitda_cell_ctl_type;

endpackage

// File: rtl/core/signed_int_to_decimal_ascii_core.sv
// After an accepted input beat, the digit cell chain converts the magnitude, taking
// 4 magnitude bits a cycle; the result then follows as 1 to 11 character beats.
// A new input beat is taken only after the last character beat of the previous one.
// Reset is synchronous and active high; it returns the controller to idle.
module signed_int_to_decimal_ascii_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sitda_pkg::CHAR_W-1:0]        rsp_character,
   output logic                                rsp_last
);
   import sitda_pkg::*;

   sitda_state_type               state_ff, state_in;
   logic [VALUE_W-1:0]            mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [CONV_CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIGIT_IDX_W-1:0]        ptr_ff, ptr_in;
   logic [DIGIT_IDX_W-1:0]        lead_idx;

   logic                          req_beat;
   logic                          rsp_beat;
   logic                          conv_done;
   sitda_cell_ctl_type            cell_ctl;

   logic [BITS_PER_CYCLE-1:0]     chain [NUM_DIGITS+1];
   logic [DIGIT_W-1:0]            digit [NUM_DIGITS];
   logic [DIGIT_W-1:0]            digit_next [NUM_DIGITS];

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign conv_done = (cnt_ff == CONV_CNT_W'(CONV_CYCLES - 1));

   assign cell_ctl.clear = req_beat;
   assign cell_ctl.shift = (state_ff == ST_CONV);

   assign chain[0] = mag_ff[VALUE_W-1 -: BITS_PER_CYCLE];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      sitda_cell u_cell (
         .clock       (clock),
         .cell_ctl    (cell_ctl),
         .bits_in     (chain[i]),
         .carries_out (chain[i+1]),
         .digit       (digit[i]),
         .digit_next  (digit_next[i])
      );
   end

   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digit_next[i] != '0) begin
            lead_idx = DIGIT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (rsp_beat) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (rsp_beat && (ptr_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_SIGN) || (state_ff == ST_DIGIT);
      rsp_last      = (state_ff == ST_DIGIT) && (ptr_ff == '0);
      rsp_character = (state_ff == ST_SIGN) ? CHAR_MINUS
                                            : CHAR_ZERO + CHAR_W'(digit[ptr_ff]);
   end

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      ptr_in = ptr_ff;
      if (req_beat) begin
         neg_in = req_value[VALUE_W-1];
         mag_in = req_value[VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         cnt_in = '0;
      end else if (state_ff == ST_CONV) begin
         mag_in = mag_ff << BITS_PER_CYCLE;
         cnt_in = cnt_ff + 1'b1;
         if (conv_done) begin
            ptr_in = lead_idx;
         end
      end else if ((state_ff == ST_DIGIT) && rsp_beat && (ptr_ff != '0)) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      ptr_ff <= ptr_in;
   end

`ifndef NO_ASSERTIONS
   a_no_digit_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (chain[NUM_DIGITS] == '0))
      else $error("digit chain overflowed past the top cell");

   a_conv_before_output: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !rsp_valid)
      else $error("result beat offered before conversion finished");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_last) |=> (!rsp_valid && !req_stall))
      else $error("block did not return to idle after the last character");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == CHAR_MINUS)) |-> !rsp_last)
      else $error("minus sign marked as the last character");

   a_output_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while characters are pending");
`endif

endmodule

// File: rtl/core/sitda_cell.sv
module sitda_cell (
   input  logic                                    clock,
   input  sitda_pkg::sitda_cell_ctl_type           cell_ctl,
   input  logic [sitda_pkg::BITS_PER_CYCLE-1:0]    bits_in,
   output logic [sitda_pkg::BITS_PER_CYCLE-1:0]    carries_out,
   output logic [sitda_pkg::DIGIT_W-1:0]           digit,
   output logic [sitda_pkg::DIGIT_W-1:0]           digit_next
);
   import sitda_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] work;

   // One shift-and-adjust step per incoming bit, most significant bit first.
   always_comb begin
      work = digit_ff;
      carries_out = '0;
      for (int j = BITS_PER_CYCLE - 1; j >= 0; j--) begin
         if (work >= 4'd5) begin
            work = work + 4'd3;
         end
         carries_out[j] = work[DIGIT_W-1];
         work = {work[DIGIT_W-2:0], bits_in[j]};
      end
      if (cell_ctl.clear) begin
         digit_in = '0;
      end else if (cell_ctl.shift) begin
         digit_in = work;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit      = digit_ff;
   assign digit_next = digit_in;

endmodule

// File: test/signed_int_to_decimal_ascii_core_tb.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;

   import sitda_pkg::*;

   localparam int DECIMAL_BASE  = 10;
   localparam int RANDOM_ITEMS  = 90;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 30;

   typedef struct {
      logic [VALUE_W-1:0] value;
      int                 phase;
      bit                 drain_first;
   } number_item_type;

   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_character;
   logic                rsp_last;

   number_item_type pending_numbers [$];
   text_char_type   expected_text [$];

   int unsigned sender_idle_pct [3]   = '{21, 81, 0};
   int unsigned receiver_idle_pct [3] = '{81, 21, 0};

   int idle_phase      = 0;
   int numbers_sent    = 0;
   int numbers_done    = 0;
   int chars_checked   = 0;
   int quiet_cycles    = 0;
   int error_count     = 0;

   signed_int_to_decimal_ascii_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
      logic [VALUE_W:0]  magnitude;
      logic [CHAR_W-1:0] digits [NUM_DIGITS];
      int                count;
      int                k;
      text_char_type     c;
      count = 0;
      magnitude = value[VALUE_W-1] ? ((33'h1_0000_0000 - {1'b0, value}) & 33'h1_FFFF_FFFF)
                                   : {1'b0, value};
      do begin
         digits[count] = CHAR_ZERO + CHAR_W'(magnitude % DECIMAL_BASE);
         magnitude = magnitude / DECIMAL_BASE;
         count++;
      end while (magnitude != 0 && count < NUM_DIGITS);
      if (value[VALUE_W-1]) begin
         c.character = CHAR_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      for (k = count - 1; k >= 0; k--) begin
         c.character = digits[k];
         c.last = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   function automatic void add_number(input logic [VALUE_W-1:0] value, input int phase,
                                      input bit drain_first);
      number_item_type item;
      item.value = value;
      item.phase = phase;
      item.drain_first = drain_first;
      pending_numbers.push_back(item);
   endfunction

   // Sender: holds each beat until accepted, and may pause until all text has drained.
   always @(posedge clock) begin
      logic            next_valid;
      number_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            numbers_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_numbers.size() > 0) begin
            if (!(pending_numbers[0].drain_first && numbers_done != numbers_sent) &&
                $urandom_range(99) >= sender_idle_pct[pending_numbers[0].phase]) begin
               item = pending_numbers.pop_front();
               idle_phase <= item.phase;
               req_value <= item.value;
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      bit            any_beat;
      text_char_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         any_beat = 1'b0;
         if (req_valid && !req_stall) begin
            push_decimal_text(req_value);
            any_beat = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            any_beat = 1'b1;
            if (expected_text.size() == 0) begin
               $error("unexpected character beat: character %0d last %0b",
                      rsp_character, rsp_last);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               chars_checked++;
               if (rsp_character !== want.character) begin
                  $error("character: expected %0d, actual %0d", want.character, rsp_character);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  error_count++;
               end
               if (want.last) begin
                  numbers_done++;
               end
            end
         end
         quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct[idle_phase]);
      end
   end

   initial begin
      logic [VALUE_W-1:0] value;
      longint             scale;
      int                 i;
      int                 j;
      int                 phase;
      bit                 timed_out;

      add_number(32'd0, 0, 1'b0);
      add_number(32'd1, 0, 1'b0);
      add_number(-32'sd1, 0, 1'b0);
      add_number(32'd9, 0, 1'b0);
      add_number(32'd10, 0, 1'b0);
      add_number(-32'sd9, 0, 1'b0);
      add_number(-32'sd10, 0, 1'b0);
      add_number(32'd99, 0, 1'b0);
      add_number(32'd100, 0, 1'b0);
      add_number(32'h7FFF_FFFF, 0, 1'b0);
      add_number(32'h8000_0000, 0, 1'b1);
      add_number(32'h8000_0001, 0, 1'b0);
      add_number(32'd1000000000, 0, 1'b0);
      add_number(32'd999999999, 0, 1'b0);
      add_number(-32'sd1000000000, 0, 1'b0);
      add_number(32'd123456789, 0, 1'b0);
      add_number(32'h5555_5555, 0, 1'b0);
      add_number(32'hAAAA_AAAA, 0, 1'b0);
      add_number(32'h8000_0000, 0, 1'b0);
      add_number(32'd0, 0, 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         phase = (i * 3) / RANDOM_ITEMS;
         case ($urandom_range(3))
            0: begin
               value = $urandom;
            end
            1: begin
               scale = 1;
               for (j = $urandom_range(1, NUM_DIGITS); j > 0; j--) begin
                  scale = scale * DECIMAL_BASE;
               end
               value = VALUE_W'(longint'($urandom) % scale);
               if ($urandom_range(1)) begin
                  value = -value;
               end
            end
            2: begin
               scale = 1;
               for (j = $urandom_range(0, NUM_DIGITS - 1); j > 0; j--) begin
                  scale = scale * DECIMAL_BASE;
               end
               value = VALUE_W'(scale + $urandom_range(2) - 1);
               if ($urandom_range(1)) begin
                  value = -value;
               end
            end
            default: begin
               value = VALUE_W'($urandom_range(40) - 20);
            end
         endcase
         add_number(value, phase,
                    (i > 0 && phase != ((i - 1) * 3) / RANDOM_ITEMS) ||
                    $urandom_range(14) == 0);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while ((pending_numbers.size() != 0 || req_valid || expected_text.size() != 0) &&
             quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      timed_out = (quiet_cycles >= QUIET_LIMIT);
      if (timed_out) begin
         $error("no beat accepted for %0d cycles", QUIET_LIMIT);
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
      if (expected_text.size() != 0) begin
         $error("%0d expected characters never arrived", expected_text.size());
         error_count++;
      end

      $display("Converted %0d numbers into %0d checked characters, with both sides idling",
               numbers_sent, chars_checked);
      $display("in turn and then neither, including the extremes and drain pauses.");
      if (error_count == 0 && !timed_out) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
